// ----- hdl/cacr_pkg.sv -----
// ----------------------------------------------------------------------------
// cacr_pkg: shared definitions for the cellular automaton cell rule
// Field widths, register indexes, reset values and rule constants.
// ----------------------------------------------------------------------------
package cacr_pkg;

    localparam int DATA_W             = 16;
    localparam int NUM_CELLS          = 9;
    localparam int CENTRE             = 4;
    localparam int CELL_WIDTH_DEFAULT = 16;

    localparam int IN_DATA_W  = DATA_W * NUM_CELLS;
    localparam int CFG_IDX_W  = 4;

    // Heat sum: eight neighbours, the flow offset and a 3-bit remainder.
    localparam int HEAT_W     = DATA_W + 4;

    // Eco rule works on the low ECO_W bits of the centre value.
    localparam int ECO_W      = 9;
    localparam int ECO_RES_W  = 10;

    typedef logic signed [DATA_W-1:0] cell_t;
    typedef logic [DATA_W-1:0]        word_t;
    typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

    localparam cfg_idx_t REG_RULE_SELECT = cfg_idx_t'(0);
    localparam cfg_idx_t REG_FLOW_OFFSET = cfg_idx_t'(1);
    localparam cfg_idx_t REG_VALUE_MASK  = cfg_idx_t'(2);
    localparam cfg_idx_t REG_FLAG_BITS   = cfg_idx_t'(3);

    localparam logic  RULE_HEAT = 1'b0;
    localparam logic  RULE_ECO  = 1'b1;

    localparam word_t VALUE_MASK_RESET = 16'd1023;
    localparam word_t FLAG_BITS_RESET  = 16'd14336;

    localparam logic [ECO_RES_W-1:0] ECO_KEEP = 10'h3fc;

endpackage

// ----- hdl/cellular_automaton_cell_rule.sv -----
// ----------------------------------------------------------------------------
// cellular_automaton_cell_rule: Moore neighbourhood cell update
// Heat diffusion rule with a carried remainder, or eco anneal/brain/antilife.
// ----------------------------------------------------------------------------
// One 3x3 neighbourhood is taken per beat and one new centre value is given
// per beat. The block sustains one beat every clock cycle while the output
// is not stalled. A beat accepted into the input register has the rule worked
// out from there, and the new value enters the output register once that
// register is empty or being taken, so an output stall holds it back. The
// heat rule's 3-bit remainder moves on as each heat beat enters the output
// register, so it is ready for the next cell in the following cycle. While
// the output is stalled one further beat is taken into the input register,
// after which the input waits. Configuration is written through the cfg
// channel, which is always ready; a write applies to every beat that enters
// the output register after it.
module cellular_automaton_cell_rule #(
    parameter int CELL_WIDTH = cacr_pkg::CELL_WIDTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // tdata, lowest bits first: cell_nw, cell_n, cell_ne, cell_w, cell_c,
    // cell_e, cell_sw, cell_s, cell_se (16 bits each)
    input  logic [cacr_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: new_cell (16 bits)
    output logic [cacr_pkg::DATA_W-1:0]    m_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  cacr_pkg::cfg_idx_t             cfg_index,
    input  logic [cacr_pkg::DATA_W-1:0]    cfg_data
);
    import cacr_pkg::*;

    localparam word_t WRAP_MASK = (CELL_WIDTH >= DATA_W) ? {DATA_W{1'b1}}
                                : DATA_W'((33'd1 << CELL_WIDTH) - 33'd1);

    logic  rule_select_reg;
    cell_t flow_offset_reg;
    word_t value_mask_reg;
    word_t flag_bits_reg;
    logic [2:0] carry_reg;
    logic [2:0] carry_next;

    logic  in_valid_reg;
    cell_t cells_reg [NUM_CELLS];
    logic  out_valid_reg;
    word_t out_data_reg;
    word_t out_data_next;

    logic out_load;
    logic in_load;

    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_select_reg <= RULE_HEAT;
            flow_offset_reg <= '0;
            value_mask_reg  <= VALUE_MASK_RESET;
            flag_bits_reg   <= FLAG_BITS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_RULE_SELECT: rule_select_reg <= cfg_data[0];
                REG_FLOW_OFFSET: flow_offset_reg <= cell_t'(cfg_data);
                REG_VALUE_MASK:  value_mask_reg  <= cfg_data;
                REG_FLAG_BITS:   flag_bits_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Rule logic between the input register and the output register
    logic signed [HEAT_W-1:0] heat_sum;
    word_t                    heat_value;
    logic [NUM_CELLS-1:0]     bit0_vec;
    logic [NUM_CELLS-1:0]     bit1_vec;
    logic [1:0]               low_diff;
    logic [3:0]               ones;
    logic [3:0]               twos;
    logic [ECO_W-1:0]         ctr;
    logic [ECO_RES_W-1:0]     eco_res;
    word_t                    eco_value;
    word_t                    rule_value;

    always_comb
    begin
        heat_sum = HEAT_W'(signed'({1'b0, carry_reg})) + HEAT_W'(flow_offset_reg);
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            if (i != CENTRE)
            begin
                heat_sum = heat_sum + HEAT_W'(cells_reg[i]);
            end
        end
        heat_value = heat_sum[DATA_W+2:3];

        // Bit 0 of each cell and bit 1 of each neighbour once the flow has been removed
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            low_diff    = cells_reg[i][1:0] - flow_offset_reg[1:0];
            bit0_vec[i] = low_diff[0];
            bit1_vec[i] = (i == CENTRE) ? 1'b0 : low_diff[1];
        end
        ones = 4'($countones(bit0_vec));
        twos = 4'($countones(bit1_vec));
        ctr  = cells_reg[CENTRE][ECO_W-1:0] - flow_offset_reg[ECO_W-1:0];

        if (ones > 4'd5 || ones == 4'd4)
        begin
            // Brian's Brain step
            eco_res = (ECO_RES_W'({ctr, 1'b0}) & ECO_KEEP) | ECO_RES_W'(1);
            if (ctr[2:1] == 2'b00 && twos == 4'd2)
            begin
                eco_res[1] = 1'b1;
            end
        end
        else
        begin
            // Anti-life step on bit 1
            eco_res = ECO_RES_W'({ctr ^ ECO_W'(2), 1'b0}) & ECO_KEEP;
            if (ctr[1])
            begin
                eco_res[1] = (twos != 4'd5);
            end
            else
            begin
                eco_res[1] = (twos != 4'd5) && (twos != 4'd6);
            end
        end
        eco_value = word_t'(flow_offset_reg) + DATA_W'(eco_res);

        rule_value    = (rule_select_reg == RULE_ECO) ? eco_value : heat_value;
        out_data_next = (rule_value & WRAP_MASK & value_mask_reg) | flag_bits_reg;

        // The remainder only moves on in the heat rule
        carry_next = (rule_select_reg == RULE_HEAT) ? heat_sum[2:0] : carry_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            carry_reg     <= '0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                in_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                carry_reg     <= carry_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            for (int i = 0; i < NUM_CELLS; i++)
            begin
                cells_reg[i] <= cell_t'(s_axis_tdata[i*DATA_W +: DATA_W]);
            end
        end
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ----- hdl/cacr_checker.sv -----
// ----------------------------------------------------------------------------
// cacr_checker: port-level checks for the cellular automaton cell rule
// Watches the stream handshakes of the top level over time.
// ----------------------------------------------------------------------------
module cacr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [cacr_pkg::DATA_W-1:0] m_axis_tdata
);
    import cacr_pkg::*;

    // No output beat may be offered while reset is held.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("output valid during reset");

    // A stalled output beat keeps its data.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output beat changed");

    // With the output register empty there is always room for a new beat.
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input refused while output is empty");

    // After each accepted beat, an output beat is on offer once the input register has been passed.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
        else $error("accepted beat did not reach the output");

endmodule

bind cellular_automaton_cell_rule cacr_checker u_cacr_checker (.*);
